>>> rtl/bsf_pkg.sv
// bsf_pkg: shared types and constants for the byte segment framer.
// Holds the frame marker bytes and the segment descriptor type.
// No dependencies.
package bsf_pkg;

  // Frame marker bytes
  localparam logic [7:0] SYNC_A  = 8'hAB;
  localparam logic [7:0] SYNC_B  = 8'hCD;
  localparam logic [7:0] TRAILER = 8'hFE;

  // Checksum seed: both sync bytes folded modulo 256
  localparam logic [8:0] SYNC_SUM  = {1'b0, SYNC_A} + {1'b0, SYNC_B};
  localparam logic [7:0] CSUM_SEED = SYNC_SUM[7:0];

  // One closed segment, handed from the front to the back
  typedef struct packed {
    logic [7:0] len;
    logic [7:0] csum;
  } desc_t;

endpackage

>>> rtl/bsf_front.sv
// bsf_front: accepts message bytes, writes them into the segment buffer and
// closes a segment when it is full or the message ends.
// Depends on bsf_pkg.
module bsf_front #(
  parameter int SEGMENT_MAX = 20,
  parameter int LW          = 5,
  parameter int AW          = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           data_byte,
  input  logic                 message_end,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [7:0]           mem_wdata,
  output logic                 desc_push,
  output bsf_pkg::desc_t       desc,
  input  logic                 bank_release
);

  localparam logic [AW-1:0] BANK1_BASE = AW'(SEGMENT_MAX);
  localparam logic [LW-1:0] SEG_LAST   = LW'(SEGMENT_MAX - 1);

  logic [LW-1:0] held_r, held_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic          wbank_r, wbank_nxt;
  logic [1:0]    busy_r, busy_nxt;
  logic          accept;
  logic          close;
  logic [7:0]    sum_new;
  logic [7:0]    len8;

  // Take a byte only while the current bank is not held by the back
  assign full   = (busy_r == 2'd2);
  assign accept = push && !full;

  // Write the byte into the current bank
  assign mem_we    = accept;
  assign mem_waddr = (wbank_r ? BANK1_BASE : '0) + AW'(held_r);
  assign mem_wdata = data_byte;

  // Close on a full segment or at message end
  assign close     = (held_r == SEG_LAST) || message_end;
  assign sum_new   = sum_r + data_byte;
  assign len8      = 8'(held_r) + 8'd1;
  assign desc_push = accept && close;
  assign desc.len  = len8;
  assign desc.csum = sum_new + bsf_pkg::CSUM_SEED + len8;

  // Advance counters, flip bank on close, track banks in use
  always_comb begin
    held_nxt  = held_r;
    sum_nxt   = sum_r;
    wbank_nxt = wbank_r;
    busy_nxt  = busy_r;
    if (accept) begin
      if (close) begin
        held_nxt  = '0;
        sum_nxt   = '0;
        wbank_nxt = !wbank_r;
      end else begin
        held_nxt = held_r + LW'(1);
        sum_nxt  = sum_new;
      end
    end
    if (desc_push && !bank_release) begin
      busy_nxt = busy_r + 2'd1;
    end else if (!desc_push && bank_release) begin
      busy_nxt = busy_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      sum_r   <= '0;
      wbank_r <= 1'b0;
      busy_r  <= '0;
    end else begin
      held_r  <= held_nxt;
      sum_r   <= sum_nxt;
      wbank_r <= wbank_nxt;
      busy_r  <= busy_nxt;
    end
  end

  // Checks
  a_busy_range : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r != 2'd3) else $error("bank busy count out of range");
  a_held_range : assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= SEG_LAST) else $error("held count past segment size");
  a_close_clears : assert property (@(posedge clk) disable iff (!rst_n)
    desc_push |=> (held_r == '0) && (sum_r == '0))
    else $error("segment state not cleared after close");
  a_no_release_idle : assert property (@(posedge clk) disable iff (!rst_n)
    bank_release |-> (busy_r != 2'd0)) else $error("release with no bank busy");

endmodule

>>> rtl/bsf_desc_q.sv
// bsf_desc_q: two-entry queue of closed segment descriptors between the
// front and the back. Depends on bsf_pkg.
module bsf_desc_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bsf_pkg::desc_t push_desc,
  input  logic           pop,
  output logic           empty,
  output bsf_pkg::desc_t head
);

  bsf_pkg::desc_t ent_r [2];
  logic           wptr_r, rptr_r;
  logic [1:0]     cnt_r, cnt_nxt;

  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rptr_r];

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_desc;
    end
  end

  // Advance pointers and count
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(pop && !empty)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && pop && !empty) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop && !empty) begin
        rptr_r <= !rptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Checks
  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != 2'd2) || pop) else $error("descriptor queue overflow");
  a_cnt_range : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("descriptor count out of range");
  a_ptr_match : assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wptr_r != rptr_r)) else $error("pointers disagree with count");

endmodule

>>> rtl/bsf_back.sv
// bsf_back: holds the two-bank segment buffer and sends each closed segment
// as a frame into a small result queue, one byte a cycle while it has room.
// Depends on bsf_pkg.
module bsf_back #(
  parameter int SEGMENT_MAX = 20,
  parameter int LW          = 5,
  parameter int AW          = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           mem_we,
  input  logic [AW-1:0]  mem_waddr,
  input  logic [7:0]     mem_wdata,
  input  logic           desc_empty,
  input  bsf_pkg::desc_t desc_head,
  output logic           desc_pop,
  output logic           bank_release,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [7:0]     out_byte,
  output logic           out_frame_done
);

  localparam int            MEM_DEPTH  = 2 * SEGMENT_MAX;
  localparam logic [AW-1:0] BANK1_BASE = AW'(SEGMENT_MAX);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SYNCA = 3'd1;
  localparam logic [2:0] ST_SYNCB = 3'd2;
  localparam logic [2:0] ST_LEN   = 3'd3;
  localparam logic [2:0] ST_PAY   = 3'd4;
  localparam logic [2:0] ST_SUM   = 3'd5;
  localparam logic [2:0] ST_TRAIL = 3'd6;

  logic [7:0]    mem [MEM_DEPTH];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] raddr;

  logic [2:0]    state_r, state_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic          rbank_r, rbank_nxt;
  bsf_pkg::desc_t cur_r, cur_nxt;

  logic          room;
  logic          issue;
  logic          iss_mem;
  logic [7:0]    iss_const;
  logic          iss_done;

  logic          s2_valid_r;
  logic          s2_mem_r;
  logic [7:0]    s2_const_r;
  logic          s2_done_r;

  logic [8:0]    oq_r [4];
  logic [1:0]    owptr_r, orptr_r;
  logic [2:0]    ocnt_r, ocnt_nxt;
  logic          opop;
  logic [8:0]    opush_data;

  // Segment buffer: one write port, one registered read port
  assign raddr = (rbank_r ? BANK1_BASE : '0) + AW'(idx_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[raddr];
  end

  // Issue a frame byte only when the result queue has a free slot
  assign room = ({1'b0, ocnt_r} + {3'b0, s2_valid_r}) < 4'd4;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    rbank_nxt    = rbank_r;
    cur_nxt      = cur_r;
    desc_pop     = 1'b0;
    bank_release = 1'b0;
    issue        = 1'b0;
    iss_mem      = 1'b0;
    iss_const    = bsf_pkg::SYNC_A;
    iss_done     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!desc_empty) begin
          desc_pop  = 1'b1;
          cur_nxt   = desc_head;
          state_nxt = ST_SYNCA;
        end
      end
      ST_SYNCA: begin
        issue     = room;
        iss_const = bsf_pkg::SYNC_A;
        if (room) state_nxt = ST_SYNCB;
      end
      ST_SYNCB: begin
        issue     = room;
        iss_const = bsf_pkg::SYNC_B;
        if (room) state_nxt = ST_LEN;
      end
      ST_LEN: begin
        issue     = room;
        iss_const = cur_r.len;
        if (room) begin
          idx_nxt   = '0;
          state_nxt = ST_PAY;
        end
      end
      ST_PAY: begin
        issue   = room;
        iss_mem = 1'b1;
        if (room) begin
          if (8'(idx_r) == cur_r.len - 8'd1) begin
            state_nxt = ST_SUM;
          end else begin
            idx_nxt = idx_r + LW'(1);
          end
        end
      end
      ST_SUM: begin
        issue     = room;
        iss_const = cur_r.csum;
        if (room) state_nxt = ST_TRAIL;
      end
      ST_TRAIL: begin
        issue     = room;
        iss_const = bsf_pkg::TRAILER;
        iss_done  = 1'b1;
        if (room) begin
          bank_release = 1'b1;
          rbank_nxt    = !rbank_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      idx_r      <= '0;
      rbank_r    <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      rbank_r    <= rbank_nxt;
      s2_valid_r <= issue;
    end
  end

  // Hold descriptor and issued-byte payload
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    s2_mem_r   <= iss_mem;
    s2_const_r <= iss_const;
    s2_done_r  <= iss_done;
  end

  // Result queue: push from second stage, pop from the port
  assign opush_data     = {s2_done_r, s2_mem_r ? rd_data_r : s2_const_r};
  assign opop           = out_pop && !out_empty;
  assign out_empty      = (ocnt_r == 3'd0);
  assign out_byte       = oq_r[orptr_r][7:0];
  assign out_frame_done = oq_r[orptr_r][8];

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      oq_r[owptr_r] <= opush_data;
    end
  end

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (s2_valid_r && !opop) begin
      ocnt_nxt = ocnt_r + 3'd1;
    end else if (!s2_valid_r && opop) begin
      ocnt_nxt = ocnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owptr_r <= '0;
      orptr_r <= '0;
      ocnt_r  <= '0;
    end else begin
      if (s2_valid_r) owptr_r <= owptr_r + 2'd1;
      if (opop) orptr_r <= orptr_r + 2'd1;
      ocnt_r <= ocnt_nxt;
    end
  end

  // Checks
  a_oq_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (ocnt_r != 3'd4) || opop) else $error("result queue overflow");
  a_oq_range : assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= 3'd4) else $error("result count out of range");
  a_release_trailer : assert property (@(posedge clk) disable iff (!rst_n)
    bank_release |=> s2_valid_r && s2_done_r) else $error("release without trailer");
  a_pop_idle_only : assert property (@(posedge clk) disable iff (!rst_n)
    desc_pop |-> (state_r == ST_IDLE)) else $error("descriptor taken mid-frame");

endmodule

>>> rtl/byte_segment_framer.sv
// byte_segment_framer: top level; cuts a byte stream into segments and sends
// each as a framed packet. Depends on bsf_pkg, bsf_front, bsf_desc_q, bsf_back.
//
//   channel  ports                                   handshake
//   input    in_data_byte, in_message_end            in_push / in_full
//   result   out_byte, out_frame_done, out_run_last  out_empty / out_pop
//
// A byte is taken in any cycle in which in_full is low; a closed segment of
// n bytes leaves as n + 5 result transfers, at most one per cycle while the
// result queue has room, after the back takes its descriptor while idle.
// The buffer has two banks: the front fills one while the back sends the other,
// and in_full rises while both banks hold closed segments.
// With the back idle, a closed segment's descriptor and then its first byte pass
// the descriptor queue, idle state, second stage and result queue to the ports.
// Synchronous reset clears all control state; buffer contents need no reset.
module byte_segment_framer #(
  parameter int SEGMENT_MAX = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_message_end,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_frame_done,
  output logic       out_run_last
);

  localparam int LW = $clog2(SEGMENT_MAX + 1);
  localparam int AW = $clog2(2 * SEGMENT_MAX);

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;
  logic           desc_push;
  bsf_pkg::desc_t desc_in;
  logic           desc_pop;
  logic           desc_empty;
  bsf_pkg::desc_t desc_head;
  logic           bank_release;

  bsf_front #(
    .SEGMENT_MAX(SEGMENT_MAX),
    .LW(LW),
    .AW(AW)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .push(in_push),
    .full(in_full),
    .data_byte(in_data_byte),
    .message_end(in_message_end),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .desc_push(desc_push),
    .desc(desc_in),
    .bank_release(bank_release)
  );

  bsf_desc_q u_desc_q (
    .clk(clk),
    .rst_n(rst_n),
    .push(desc_push),
    .push_desc(desc_in),
    .pop(desc_pop),
    .empty(desc_empty),
    .head(desc_head)
  );

  bsf_back #(
    .SEGMENT_MAX(SEGMENT_MAX),
    .LW(LW),
    .AW(AW)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .desc_empty(desc_empty),
    .desc_head(desc_head),
    .desc_pop(desc_pop),
    .bank_release(bank_release),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_byte(out_byte),
    .out_frame_done(out_frame_done)
  );

  // A frame is the whole output of one segment, so its trailer ends the run
  assign out_run_last = out_frame_done;

endmodule

>>> test/tb_byte_segment_framer.sv
// tb_byte_segment_framer: self-checking testbench for byte_segment_framer.
// Predicts every frame byte from the accepted input bytes and checks each result transfer.
// Depends on bsf_pkg and the byte_segment_framer RTL.
module tb_byte_segment_framer;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEG_MAX     = 20;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 40;
  localparam int MAX_PRINTS  = 60;

  // One expected frame byte with its flags
  typedef struct {
    logic [7:0] value;
    logic       done;
    logic       last;
  } frame_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_message_end = 1'b0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [7:0] out_byte;
  logic       out_frame_done;
  logic       out_run_last;

  // Predictor state and the store of pending frame bytes
  logic [7:0]  held_bytes[$];
  frame_beat_t pending_frame_bytes[$];

  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int pop_wait = 0;

  int cycle_count     = 0;
  int error_count     = 0;
  int bytes_sent      = 0;
  int messages_sent   = 0;
  int frames_checked  = 0;
  int results_checked = 0;

  byte_segment_framer #(
    .SEGMENT_MAX(SEG_MAX)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_data_byte   (in_data_byte),
    .in_message_end (in_message_end),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_byte       (out_byte),
    .out_frame_done (out_frame_done),
    .out_run_last   (out_run_last)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frame bytes still pending",
               cycle_count, pending_frame_bytes.size());
      $display("byte_segment_framer regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("mismatch at result %0d (cycle %0d): %s", results_checked, cycle_count, msg);
  endtask

  // Append one expected frame byte
  function automatic void queue_beat(input logic [7:0] value, input logic done);
    frame_beat_t beat;
    beat = '{value, done, done};
    pending_frame_bytes.insert(pending_frame_bytes.size(), beat);
  endfunction

  // Hold one byte; close the segment when it is full or the message ends
  function automatic void frame_predict(input logic [7:0] data, input logic msg_end);
    logic [7:0]  seg_len;
    logic [7:0]  csum;
    if (held_bytes.size() < SEG_MAX)
      held_bytes.insert(held_bytes.size(), data);
    if (held_bytes.size() >= SEG_MAX || msg_end) begin
      seg_len = 8'(held_bytes.size());
      csum = bsf_pkg::CSUM_SEED + seg_len;
      queue_beat(bsf_pkg::SYNC_A, 1'b0);
      queue_beat(bsf_pkg::SYNC_B, 1'b0);
      queue_beat(seg_len, 1'b0);
      foreach (held_bytes[i]) begin
        csum = csum + held_bytes[i];
        queue_beat(held_bytes[i], 1'b0);
      end
      queue_beat(csum, 1'b0);
      queue_beat(bsf_pkg::TRAILER, 1'b1);
      held_bytes.delete();
    end
  endfunction

  // Compare one result transfer against the oldest pending frame byte
  task automatic check_result();
    frame_beat_t want;
    if (pending_frame_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected result byte %h", out_byte));
    end else begin
      want = pending_frame_bytes.pop_front();
      if (out_byte !== want.value)
        report_mismatch($sformatf("out_byte %h, want %h", out_byte, want.value));
      if (out_frame_done !== want.done)
        report_mismatch($sformatf("out_frame_done %b, want %b", out_frame_done, want.done));
      if (out_run_last !== want.last)
        report_mismatch($sformatf("out_run_last %b, want %b", out_run_last, want.last));
      if (want.done)
        frames_checked++;
    end
    results_checked++;
  endtask

  // Result side: check each transfer, then pause popping for a random gap unless rx_burst is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        check_result();
        pop_wait = rx_burst ? 0 : $urandom_range(0, 19);
      end
      if (pop_wait > 0) begin
        out_pop <= 1'b0;
        pop_wait--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Wait a random gap, then hold the byte until it transfers
  task automatic send_byte(input logic [7:0] data, input logic msg_end);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push        <= 1'b1;
    in_data_byte   <= data;
    in_message_end <= msg_end;
    do @(posedge clk); while (in_full);
    frame_predict(data, msg_end);
    bytes_sent++;
    if (msg_end)
      messages_sent++;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // Mostly short messages, some spanning several segments
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6)
      return $urandom_range(1, 6);
    else if (r < 9)
      return $urandom_range(7, 25);
    return $urandom_range(26, 60);
  endfunction

  // Hold off input until every pending frame byte has transferred
  task automatic drain_outputs();
    in_push <= 1'b0;
    while (pending_frame_bytes.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Single-byte messages at both byte extremes
  task automatic test_single_byte();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  // Message that ends exactly on a full segment; checksum wraps
  task automatic test_full_segment_end();
    for (int i = 0; i < SEG_MAX; i++)
      send_byte((i % 2) ? 8'h00 : 8'hFF, i == SEG_MAX - 1);
  endtask

  // Random messages with random idling on both sides, some stretches without
  task automatic test_random_mixed(input int target);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      send_message(pick_length());
    end
  endtask

  // Fast sender against a slow receiver, so in_full rises
  task automatic test_back_pressure(input int target);
    int start;
    start = bytes_sent;
    tx_burst = 1'b1;
    rx_burst = 1'b0;
    while (bytes_sent - start < target)
      send_message(pick_length());
  endtask

  // Both sides at full rate
  task automatic test_streaming(input int target);
    int start;
    start = bytes_sent;
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    while (bytes_sent - start < target)
      send_message(pick_length());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_byte();
    test_full_segment_end();
    test_random_mixed(180);
    test_back_pressure(130);
    drain_outputs();
    test_streaming(130);

    // Stop input, let every pending frame byte out, then watch for strays
    in_push  <= 1'b0;
    rx_burst = 1'b1;
    while (pending_frame_bytes.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("sent %0d bytes in %0d messages; checked %0d result bytes in %0d frames",
             bytes_sent, messages_sent, results_checked, frames_checked);
    $display("%0d mismatches over %0d cycles", error_count, cycle_count);
    if (error_count == 0)
      $display("byte_segment_framer regression: pass");
    else
      $display("byte_segment_framer regression: fail");
    $finish;
  end

endmodule

>>> byte_segment_framer.f
rtl/bsf_pkg.sv
rtl/bsf_front.sv
rtl/bsf_desc_q.sv
rtl/bsf_back.sv
rtl/byte_segment_framer.sv
test/tb_byte_segment_framer.sv
